### design/sensor_frame_header_parser_top_defines.svh
// assertion macros for the sensor frame header parser
// used by sensor_frame_header_parser_top; expects clk_i and rst_ni in scope
`ifndef SENSOR_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define SENSOR_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define SFHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is active
`define SFHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sfhp_pkg.sv
// shared types and constants of the sensor frame header parser
// no dependencies; imported by the interfaces and all modules
`default_nettype none

package sfhp_pkg;

  // widths
  localparam int unsigned POS_W   = 17;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

  // frame layout
  localparam logic [POS_W-1:0] POS_START_HI  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_START_LO  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEQ_HI    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_SEQ_LO    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_TS_HI     = POS_W'(4);
  localparam logic [POS_W-1:0] POS_TS_LO     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_SENSOR    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_STATUS    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(8);
  localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(9);
  localparam logic [POS_W-1:0] HEADER_BYTES  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};

  // frame status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_START  = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SENSOR = 3'd2;
  localparam logic [STAT_W-1:0] ST_SHORT_PAY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_TRUNC_HDR  = 3'd4;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes and reset values
  localparam logic CFG_START_WORD    = 1'b0;
  localparam logic CFG_SENSOR_STATUS = 1'b1;
  localparam logic [15:0] START_WORD_RST    = 16'hABCD;
  localparam logic [7:0]  SENSOR_STATUS_RST = 8'h01;

  // one result item
  typedef struct packed {
    logic              result_kind;
    logic [7:0]        payload_byte;
    logic [STAT_W-1:0] frame_status;
    logic [15:0]       sequence_number;
    logic [15:0]       send_timestamp;
    logic [7:0]        sensor_id;
    logic [15:0]       data_length;
    logic [POS_W-1:0]  payload_count;
    logic              last_of_run;
  } res_t;

  // results produced by one accepted byte, in order
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  // queue status seen by the top level
  typedef struct packed {
    logic [FIFO_CW-1:0] level;
    logic               has_room;
  } fifo_stat_t;

endpackage

`default_nettype wire

### design/sfhp_if.sv
// request channels of the sensor frame header parser
// input byte channel and result channel; depends on sfhp_pkg
`default_nettype none

interface sfhp_in_if import sfhp_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface sfhp_out_if import sfhp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [7:0]        payload_byte;
  logic [STAT_W-1:0] frame_status;
  logic [15:0]       sequence_number;
  logic [15:0]       send_timestamp;
  logic [7:0]        sensor_id;
  logic [15:0]       data_length;
  logic [POS_W-1:0]  payload_count;
  logic              last_of_run;

  modport source (
    output valid, output result_kind, output payload_byte, output frame_status,
    output sequence_number, output send_timestamp, output sensor_id,
    output data_length, output payload_count, output last_of_run, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input frame_status,
    input sequence_number, input send_timestamp, input sensor_id,
    input data_length, input payload_count, input last_of_run, output ready
  );
endinterface

`default_nettype wire

### design/sfhp_parse.sv
// header parse state, configuration registers and result forming
// one accepted byte updates the state and yields up to two results; uses sfhp_pkg
`default_nettype none

module sfhp_parse import sfhp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_end_i,
  output push_t            push_o
);

  logic [15:0]       exp_start_q;
  logic [7:0]        exp_status_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       start_q, start_d;
  logic [15:0]       seq_q, seq_d;
  logic [15:0]       ts_q, ts_d;
  logic [7:0]        sensor_q, sensor_d;
  logic [15:0]       len_q, len_d;
  logic [STAT_W-1:0] err_q, err_d;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  count;
  logic [STAT_W-1:0] sum_status;
  logic              pay_v;
  res_t              pay_res, sum_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_start_q  <= START_WORD_RST;
      exp_status_q <= SENSOR_STATUS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_WORD:    exp_start_q  <= cfg_wdata_i;
        CFG_SENSOR_STATUS: exp_status_q <= cfg_wdata_i[7:0];
        default:           exp_start_q  <= exp_start_q;
      endcase
    end
  end

  // header field capture and error checks for this byte
  always_comb begin
    start_d  = start_q;
    seq_d    = seq_q;
    ts_d     = ts_q;
    sensor_d = sensor_q;
    len_d    = len_q;
    err_d    = err_q;
    unique case (pos_q)
      POS_START_HI: start_d = {data_byte_i, 8'h00};
      POS_START_LO: begin
        start_d = {start_q[15:8], data_byte_i};
        if (err_q == ST_OK && {start_q[15:8], data_byte_i} != exp_start_q) begin
          err_d = ST_BAD_START;
        end
      end
      POS_SEQ_HI:   seq_d    = {data_byte_i, 8'h00};
      POS_SEQ_LO:   seq_d    = {seq_q[15:8], data_byte_i};
      POS_TS_HI:    ts_d     = {data_byte_i, 8'h00};
      POS_TS_LO:    ts_d     = {ts_q[15:8], data_byte_i};
      POS_SENSOR:   sensor_d = data_byte_i;
      POS_STATUS: begin
        if (err_q == ST_OK && data_byte_i != exp_status_q) begin
          err_d = ST_BAD_SENSOR;
        end
      end
      POS_LEN_HI:   len_d    = {data_byte_i, 8'h00};
      POS_LEN_LO:   len_d    = {len_q[15:8], data_byte_i};
      default:      err_d    = err_q;
    endcase
  end

  // saturating position and payload count
  assign pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
  assign count   = (pos_inc > HEADER_BYTES) ? pos_inc - HEADER_BYTES : '0;

  // summary status: first error, else truncation, else short payload
  always_comb begin
    priority if (err_d != ST_OK) begin
      sum_status = err_d;
    end else if (pos_q < POS_LEN_LO) begin
      sum_status = ST_TRUNC_HDR;
    end else if (count < {1'b0, len_d}) begin
      sum_status = ST_SHORT_PAY;
    end else begin
      sum_status = ST_OK;
    end
  end

  assign pay_v = (pos_q >= HEADER_BYTES) && (err_d == ST_OK);

  // result items
  always_comb begin
    pay_res.result_kind     = KIND_PAYLOAD;
    pay_res.payload_byte    = data_byte_i;
    pay_res.frame_status    = ST_OK;
    pay_res.sequence_number = seq_d;
    pay_res.send_timestamp  = ts_d;
    pay_res.sensor_id       = sensor_d;
    pay_res.data_length     = len_d;
    pay_res.payload_count   = count;
    pay_res.last_of_run     = !frame_end_i;

    sum_res                 = pay_res;
    sum_res.result_kind     = KIND_SUMMARY;
    sum_res.payload_byte    = 8'h00;
    sum_res.frame_status    = sum_status;
    sum_res.last_of_run     = 1'b1;
  end

  always_comb begin
    push_o.second = sum_res;
    push_o.first  = pay_v ? pay_res : sum_res;
    if (!accept_i) begin
      push_o.num = 2'd0;
    end else begin
      push_o.num = 2'({1'b0, pay_v} + {1'b0, frame_end_i});
    end
  end

  // frame end returns all frame state to reset
  always_comb begin
    pos_d = pos_inc;
    if (frame_end_i) begin
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      seq_q    <= '0;
      ts_q     <= '0;
      sensor_q <= '0;
      len_q    <= '0;
      err_q    <= ST_OK;
    end else if (accept_i) begin
      pos_q <= pos_d;
      if (frame_end_i) begin
        start_q  <= '0;
        seq_q    <= '0;
        ts_q     <= '0;
        sensor_q <= '0;
        len_q    <= '0;
        err_q    <= ST_OK;
      end else begin
        start_q  <= start_d;
        seq_q    <= seq_d;
        ts_q     <= ts_d;
        sensor_q <= sensor_d;
        len_q    <= len_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

`default_nettype wire

### design/sfhp_fifo.sv
// result queue: takes up to two results per cycle, hands out one
// decouples the parser from a stalling receiver; uses sfhp_pkg
`default_nettype none

module sfhp_fifo import sfhp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire push_t push_i,
  input  wire logic pop_i,
  output res_t      head_o,
  output fifo_stat_t stat_o
);

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic [FIFO_AW-1:0] wr_next;
  logic               do_pop;

  assign wr_next = wr_q + FIFO_AW'(1);
  assign do_pop  = pop_i && (cnt_q != '0);

  // storage writes
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + FIFO_AW'(push_i.num);
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + FIFO_CW'(push_i.num) - FIFO_CW'(do_pop);
    end
  end

  assign head_o          = mem_q[rd_q];
  assign stat_o.level    = cnt_q;
  assign stat_o.has_room = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

### design/sensor_frame_header_parser_top.sv
// Sensor frame header parser, top level.
// Byte channel in_i (data_byte, frame_end) and result channel out_o, both
// valid/ready; configuration by a write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
// index 0 the expected start word, index 1 the expected sensor status.
// Each accepted byte gives zero, one or two results: a payload result for a
// byte after the 10-byte header while no error is known, and a summary on the
// frame's last byte.
// A result is offered in the cycle after its byte is accepted when the
// queue is empty, and later when it waits behind earlier results.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver is ready; a byte that gives two results adds to the
// backlog, since the four-entry result queue drains one result per cycle.
// in_i.ready is high while the queue has room for two results, so a
// stalled receiver fills the queue and then holds off input; nothing is lost.
// Reset clears the frame state and the queue and loads the register defaults
// (start word 0xABCD, sensor status 0x01); no clearing pass is needed.
// Depends on sfhp_pkg, sfhp_if, sfhp_parse, sfhp_fifo and the defines header.
`default_nettype none

`include "sensor_frame_header_parser_top_defines.svh"

module sensor_frame_header_parser_top import sfhp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sfhp_in_if.sink          in_i,
  sfhp_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  push_t      push;
  res_t       head;
  fifo_stat_t fstat;
  logic       accept;
  logic       pop;

  // input handshake
  assign in_i.ready = fstat.has_room;
  assign accept     = in_i.valid && fstat.has_room;

  sfhp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .frame_end_i (in_i.frame_end),
    .push_o      (push)
  );

  assign pop = out_o.valid && out_o.ready;

  sfhp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fstat)
  );

  // result channel
  assign out_o.valid           = (fstat.level != '0);
  assign out_o.result_kind     = head.result_kind;
  assign out_o.payload_byte    = head.payload_byte;
  assign out_o.frame_status    = head.frame_status;
  assign out_o.sequence_number = head.sequence_number;
  assign out_o.send_timestamp  = head.send_timestamp;
  assign out_o.sensor_id       = head.sensor_id;
  assign out_o.data_length     = head.data_length;
  assign out_o.payload_count   = head.payload_count;
  assign out_o.last_of_run     = head.last_of_run;

  // checks
  `SFHP_ASSERT_NEXT(a_end_gives_result, accept && in_i.frame_end, out_o.valid,
    "frame end accepted but no result offered")
  `SFHP_ASSERT_NOW(a_summary_is_last, out_o.valid && out_o.result_kind == KIND_SUMMARY,
    out_o.last_of_run, "summary result not marked last of run")
  `SFHP_ASSERT_NOW(a_payload_ok, out_o.valid && out_o.result_kind == KIND_PAYLOAD,
    out_o.frame_status == ST_OK && out_o.payload_count != '0,
    "payload result with error status or zero count")
  `SFHP_ASSERT_NOW(a_queue_bound, 1'b1, fstat.level <= FIFO_CW'(FIFO_DEPTH),
    "result queue overflow")

endmodule

`default_nettype wire
